// ===== design/scff_pkg.sv =====
// Shared types and constants for the chunk fill framer.
// No dependencies; imported by every module of the block.
package scff_pkg;

  localparam int CHUNK_BYTES_DEF = 32;
  localparam int FILL_BYTES_DEF  = 2;
  localparam int ALIGN_BYTES_DEF = 4;

  localparam int LEAD_W  = 3;  // holds up to seven leading fill bytes
  localparam int TRAIL_W = 2;  // holds up to three padding bytes
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE     = 1'd1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] FILL_RESET = 8'hFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [LEAD_W-1:0]  lead;
    logic [7:0]         data;
    logic               data_valid;
    logic [TRAIL_W-1:0] trail;
    logic               last;
  } job_t;

endpackage

// ===== design/scff_front.sv =====
// Front end: accepts input requests, tracks chunk position and length, and
// classifies each request into an expansion job. Depends on scff_pkg.
module scff_front #(
  parameter int CHUNK_BYTES = scff_pkg::CHUNK_BYTES_DEF,
  parameter int FILL_BYTES  = scff_pkg::FILL_BYTES_DEF,
  parameter int ALIGN_BYTES = scff_pkg::ALIGN_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scff_pkg::in_item_t in_data,
  input  logic              mode,
  output logic              push_valid,
  output scff_pkg::job_t    push_job,
  input  logic              push_ready
);
  import scff_pkg::*;

  localparam int GROUP = CHUNK_BYTES + FILL_BYTES;
  localparam int PW    = $clog2(GROUP);
  localparam int AW    = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] lma_r, lma_nxt;
  logic [PW:0]   pos_inc;
  logic [AW-1:0] lma_inc;
  logic [TRAIL_W-1:0] pad;
  logic          dropped;
  logic          accept;

  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;
  assign pos_inc  = {1'b0, pos_r} + {{PW{1'b0}}, 1'b1};
  assign dropped  = ({1'b0, pos_r} < (PW+1)'(FILL_BYTES));
  assign lma_inc  = (lma_r == AW'(ALIGN_BYTES - 1)) ? '0 : lma_r + AW'(1);

  always_comb begin
    if (lma_inc == '0) begin
      pad = '0;
    end else begin
      pad = TRAIL_W'(ALIGN_BYTES - int'(lma_inc));
    end
  end

  always_comb begin
    push_job = '0;
    push_job.data = in_data.in_byte;
    push_job.last = in_data.frame_end;
    if (mode == MODE_ENCODE) begin
      push_job.lead       = (pos_r == '0) ? LEAD_W'(FILL_BYTES) : '0;
      push_job.data_valid = 1'b1;
      push_job.trail      = in_data.frame_end ? pad : '0;
      push_valid          = in_valid;
      pos_nxt = (pos_inc >= (PW+1)'(CHUNK_BYTES)) ? '0 : pos_inc[PW-1:0];
      lma_nxt = lma_inc;
    end else begin
      push_job.data_valid = ~dropped;
      if (dropped) begin
        push_job.data = '0;
      end
      push_valid = in_valid & (~dropped | in_data.frame_end);
      pos_nxt = (pos_inc >= (PW+1)'(GROUP)) ? '0 : pos_inc[PW-1:0];
      lma_nxt = '0;
    end
    if (in_data.frame_end) begin
      pos_nxt = '0;
      lma_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      lma_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      lma_r <= lma_nxt;
    end
  end

endmodule

// ===== design/scff_queue.sv =====
// Short job queue between front and back ends.
// Depends on scff_pkg for the job type and depth.
module scff_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  scff_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop,
  output scff_pkg::job_t pop_job
);
  import scff_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/scff_back.sv =====
// Back end: expands each job into fill, byte and padding results, one per
// cycle unless the output stalls, through a registered output stage. Depends on scff_pkg.
module scff_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          fill_value,
  input  logic                pop_valid,
  output logic                pop,
  input  scff_pkg::job_t      pop_job,
  output logic                out_valid,
  input  logic                out_ready,
  output scff_pkg::out_item_t out_data
);
  import scff_pkg::*;

  logic               cur_v_r;
  logic [LEAD_W-1:0]  lead_r;
  logic               pend_r;
  logic [7:0]         data_r;
  logic               dvalid_r;
  logic [TRAIL_W-1:0] trail_r;
  logic               last_r;
  logic               out_valid_r;
  out_item_t          out_data_r, res;
  logic               slot_free, emit, done;

  assign slot_free = ~out_valid_r | out_ready;
  assign emit      = cur_v_r & slot_free;
  assign done      = (lead_r == '0) &&
                     ((pend_r && trail_r == '0) || (!pend_r && trail_r == TRAIL_W'(1)));
  assign pop       = pop_valid & (~cur_v_r | (emit & done));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    res = '0;
    if (lead_r != '0) begin
      res.out_byte   = fill_value;
      res.byte_valid = 1'b1;
    end else if (pend_r) begin
      res.out_byte   = data_r;
      res.byte_valid = dvalid_r;
      res.frame_last = last_r & (trail_r == '0);
    end else begin
      res.out_byte   = fill_value;
      res.byte_valid = 1'b1;
      res.frame_last = last_r & (trail_r == TRAIL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid_r <= emit;
      end
      if (pop) begin
        cur_v_r <= 1'b1;
      end else if (emit && done) begin
        cur_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
    if (pop) begin
      lead_r   <= pop_job.lead;
      pend_r   <= 1'b1;
      data_r   <= pop_job.data;
      dvalid_r <= pop_job.data_valid;
      trail_r  <= pop_job.trail;
      last_r   <= pop_job.last;
    end else if (emit) begin
      if (lead_r != '0) begin
        lead_r <= lead_r - LEAD_W'(1);
      end else if (pend_r) begin
        pend_r <= 1'b0;
      end else begin
        trail_r <= trail_r - TRAIL_W'(1);
      end
    end
  end

endmodule

// ===== design/spi_chunk_fill_framer.sv =====
// Top level of the chunk fill framer: configuration registers, front end,
// job queue and back end. Depends on scff_pkg, scff_front, scff_queue, scff_back.
//
//   channel | ports                          | carries
//   in      | in_valid, in_ready, in_data     | one frame byte and its end flag
//   out     | out_valid, out_ready, out_data  | one fill, payload or padding byte
//   cfg     | cfg_we, cfg_index, cfg_data     | direction mode, fill byte
//
// The back end sends one result per cycle unless the output stalls; an input byte
// yields zero to six results, and each job that is queued gives at least one.
// The front end takes a new byte every cycle while the two-entry job queue has room.
// Reset is synchronous, clears position, length, queue and output stage, and restores the configuration defaults.
// A stalled output holds its result and backs up through the queue to in_ready.
module spi_chunk_fill_framer #(
  parameter int CHUNK_BYTES = scff_pkg::CHUNK_BYTES_DEF,
  parameter int FILL_BYTES  = scff_pkg::FILL_BYTES_DEF,
  parameter int ALIGN_BYTES = scff_pkg::ALIGN_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  scff_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output scff_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [scff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scff_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scff_pkg::*;

  logic       mode_r;
  logic [7:0] fill_r;
  logic       push_valid, push_ready, pop_valid, pop;
  job_t       push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      fill_r <= FILL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION_MODE: mode_r <= cfg_data[0];
        CFG_FILL_VALUE:     fill_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  scff_front #(
    .CHUNK_BYTES(CHUNK_BYTES),
    .FILL_BYTES (FILL_BYTES),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mode      (mode_r),
    .push_valid(push_valid),
    .push_job  (push_job),
    .push_ready(push_ready)
  );

  scff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job)
  );

  scff_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fill_value(fill_r),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
